### src/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg: shared types and constants for the decimal string parser
// Beat types for both channels, the queued operation format, phase codes
// and the numeric limits used by the accumulator.
// ----------------------------------------------------------------------------
package dsi_pkg;

    localparam int unsigned DEF_MAX_LEN     = 32'd65535;
    localparam int unsigned DEF_QUEUE_DEPTH = 4;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned MAG_W   = 64;
    // room for 10*m + d with m up to 2^63
    localparam int unsigned PROD_W  = MAG_W + 4;

    localparam logic [MAG_W-1:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [MAG_W-1:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_text;

    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic               out_of_range;
        logic [15:0]        consumed_count;
    } t_result;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE,   // byte ignored
        OP_COUNT,  // whitespace or plus sign: count only
        OP_NEG,    // minus sign
        OP_DIGIT   // decimal digit
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [3:0] digit;
        logic       last;
    } t_op;

endpackage

### src/dsi_front.sv
// ----------------------------------------------------------------------------
// dsi_front: byte classifier
// Tracks the parse phase and turns each accepted byte into a queued op.
// ----------------------------------------------------------------------------
module dsi_front
    import dsi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_text i_text,
    output t_op   o_op
);

    t_phase r_phase;
    t_phase n_phase;
    logic   is_blank;
    logic   is_digit;

    assign is_blank = (i_text.text_byte == CH_SPACE) ||
                      ((i_text.text_byte >= CH_TAB) && (i_text.text_byte <= CH_CR));
    assign is_digit = (i_text.text_byte >= CH_ZERO) && (i_text.text_byte <= CH_NINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        o_op.kind  = OP_NONE;
        o_op.digit = 4'(i_text.text_byte - CH_ZERO);
        o_op.last  = i_text.last_byte;
        unique case (r_phase)
            PH_SPACE: begin
                if (is_blank) begin
                    o_op.kind = OP_COUNT;
                end else if (i_text.text_byte == CH_MINUS) begin
                    o_op.kind = OP_NEG;
                    n_phase   = PH_DIGITS;
                end else if (i_text.text_byte == CH_PLUS) begin
                    o_op.kind = OP_COUNT;
                    n_phase   = PH_DIGITS;
                end else if (is_digit) begin
                    o_op.kind = OP_DIGIT;
                    n_phase   = PH_DIGITS;
                end else begin
                    n_phase   = PH_STOP;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    o_op.kind = OP_DIGIT;
                end else begin
                    n_phase   = PH_STOP;
                end
            end
            PH_STOP: begin
                o_op.kind = OP_NONE;
            end
            default: begin
                n_phase = PH_SPACE;
            end
        endcase
        if (!i_accept) begin
            n_phase = r_phase;
        end else if (i_text.last_byte) begin
            n_phase = PH_SPACE;
        end
    end

endmodule

### src/dsi_queue.sv
// ----------------------------------------------------------------------------
// dsi_queue: op queue between classifier and accumulator
// Small register queue; lets either side stall on its own.
// ----------------------------------------------------------------------------
module dsi_queue
    import dsi_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_take
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          do_wr;
    logic          do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_take && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_rd) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

### src/dsi_back.sv
// ----------------------------------------------------------------------------
// dsi_back: accumulator and result stage
// Multiply-by-ten accumulate with exact overflow test, byte count, then a
// final stage that applies sign and saturation into the output register.
// ----------------------------------------------------------------------------
module dsi_back
    import dsi_pkg::*;
#(
    parameter int unsigned MAX_LEN = DEF_MAX_LEN
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_op_valid,
    input  t_op     i_op,
    output logic    o_op_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_LEN > 32'd65535) ? 16'hFFFF : COUNT_W'(MAX_LEN);

    // running parse state
    logic               r_neg;
    logic [MAG_W-1:0]   r_mag;
    logic               r_ovf;
    logic [COUNT_W-1:0] r_cnt;
    logic               n_neg;
    logic [MAG_W-1:0]   n_mag;
    logic               n_ovf;
    logic [COUNT_W-1:0] n_cnt;

    // finished string, waiting for the output register
    logic               r_fin_valid;
    logic               r_fin_neg;
    logic [MAG_W-1:0]   r_fin_mag;
    logic               r_fin_ovf;
    logic [COUNT_W-1:0] r_fin_cnt;

    logic               r_out_valid;
    t_result            r_out;

    logic               a_neg;
    logic [MAG_W-1:0]   a_mag;
    logic               a_ovf;
    logic [COUNT_W-1:0] a_cnt;
    logic [PROD_W-1:0]  prod;
    logic [MAG_W-1:0]   limit;
    logic               bump;
    logic               fin_move;
    logic               pop_fire;
    logic               take;

    assign pop_fire  = i_pop && r_out_valid;
    assign fin_move  = r_fin_valid && (!r_out_valid || pop_fire);
    assign take      = i_op_valid && (!i_op.last || !r_fin_valid || fin_move);
    assign o_op_take = take;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    assign limit = r_neg ? LIMIT_NEG : LIMIT_POS;
    assign prod  = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + PROD_W'(i_op.digit);
    assign bump  = (r_cnt < COUNT_CAP);

    always_comb begin
        a_neg = r_neg;
        a_mag = r_mag;
        a_ovf = r_ovf;
        a_cnt = r_cnt;
        unique case (i_op.kind)
            OP_NONE: begin
                a_cnt = r_cnt;
            end
            OP_COUNT: begin
                if (bump) a_cnt = r_cnt + 1'b1;
            end
            OP_NEG: begin
                a_neg = 1'b1;
                if (bump) a_cnt = r_cnt + 1'b1;
            end
            OP_DIGIT: begin
                if (!r_ovf) begin
                    // 10*m + d > limit is the same test as m > (limit - d) / 10
                    if (prod > {4'b0, limit}) begin
                        a_ovf = 1'b1;
                    end else begin
                        a_mag = prod[MAG_W-1:0];
                    end
                end
                if (bump) a_cnt = r_cnt + 1'b1;
            end
            default: begin
                a_cnt = r_cnt;
            end
        endcase

        n_neg = r_neg;
        n_mag = r_mag;
        n_ovf = r_ovf;
        n_cnt = r_cnt;
        if (take) begin
            if (i_op.last) begin
                n_neg = 1'b0;
                n_mag = '0;
                n_ovf = 1'b0;
                n_cnt = '0;
            end else begin
                n_neg = a_neg;
                n_mag = a_mag;
                n_ovf = a_ovf;
                n_cnt = a_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_ovf       <= n_ovf;
            r_cnt       <= n_cnt;
            r_fin_valid <= (r_fin_valid && !fin_move) || (take && i_op.last);
            r_out_valid <= (r_out_valid && !pop_fire) || fin_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_op.last) begin
            r_fin_neg <= a_neg;
            r_fin_mag <= a_mag;
            r_fin_ovf <= a_ovf;
            r_fin_cnt <= a_cnt;
        end
        if (fin_move) begin
            if (r_fin_ovf) begin
                r_out.parsed_value <= r_fin_neg ? signed'(LIMIT_NEG) : signed'(LIMIT_POS);
            end else if (r_fin_neg) begin
                r_out.parsed_value <= signed'(MAG_W'(0) - r_fin_mag);
            end else begin
                r_out.parsed_value <= signed'(r_fin_mag);
            end
            r_out.out_of_range   <= r_fin_ovf;
            r_out.consumed_count <= r_fin_cnt;
        end
    end

endmodule

### src/decimal_string_to_int64.sv
// ----------------------------------------------------------------------------
// decimal_string_to_int64: streaming decimal text to saturating int64
// Skips leading whitespace, takes an optional sign, accumulates digits and
// gives one result beat per string, on its final byte.
//
//   channel | handshake         | beat
//   --------+-------------------+------------------------------------------
//   input   | push / full       | i_text   : text_byte, last_byte
//   result  | empty / pop       | o_result : parsed_value, out_of_range,
//           |                   |            consumed_count
//
// One byte per cycle sustained while results are popped; the multiply-by-ten
// accumulate in the back end is the loop through r_mag that sets that rate.
// A result reaches the result side through the op queue write of its final
// byte, then accumulate, then the sign/saturate stage.
// Reset is synchronous, active low; no clearing pass, the block takes
// bytes from the first cycle after reset.
// A stalled result side fills the op queue, then full rises; bytes that
// cause no result keep flowing as long as the queue has room.
// ----------------------------------------------------------------------------
module decimal_string_to_int64
    import dsi_pkg::*;
#(
    parameter int unsigned MAX_LEN     = DEF_MAX_LEN,
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_text   i_text,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic accept;   // input beat taken this cycle
    t_op  front_op;
    t_op  q_op;
    logic q_full;
    logic q_valid;
    logic q_take;

    assign full   = q_full;
    assign accept = push && !q_full;

    // front: phase tracking and byte classification
    dsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_text  (i_text),
        .o_op    (front_op)
    );

    // decoupling queue between classifier and accumulator
    dsi_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_op   (front_op),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_op   (q_op),
        .i_take (q_take)
    );

    // back: accumulate, count, sign and saturate, output register
    dsi_back #(
        .MAX_LEN(MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_valid(q_valid),
        .i_op      (q_op),
        .o_op_take (q_take),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

### src/dsi_chk.sv
// ----------------------------------------------------------------------------
// dsi_chk: port-level checks for decimal_string_to_int64
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module dsi_chk
    import dsi_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // a waiting result beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result beat changed while waiting");

    // reset leaves the result side empty and full low
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not empty after reset");

    // saturated results sit exactly on a limit
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_of_range) |->
        (o_result.parsed_value == signed'(LIMIT_NEG) ||
         o_result.parsed_value == signed'(LIMIT_POS)))
        else $error("overflow result not saturated");

    // a nonzero value comes with a nonzero consumed count
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.parsed_value != 64'sd0) |->
        (o_result.consumed_count != 16'd0))
        else $error("nonzero value with zero consumed count");

endmodule

bind decimal_string_to_int64 dsi_chk u_dsi_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_result(o_result)
);
